/* rtl/core/page_free_list_allocator_top_defines.svh */
// Assertion macros shared by the page allocator RTL.
// Included by files that carry concurrent checks; depends on clk and rst_n in scope.
`ifndef PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define PFLA_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);
// Antecedent on one edge implies the consequent on the next edge.
`define PFLA_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PFLA_ASSERT(name, prop, msg)
`define PFLA_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

/* rtl/core/pfla_pkg.sv */
// Shared types and constants of the page free-list allocator.
// No dependencies; used by the interfaces, the link store and the top level.
package pfla_pkg;

    localparam int PAGE_W   = 10;
    localparam int TOTAL_W  = 11;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 2;

    localparam int PAGE_COUNT_DEF = 1024;
    localparam int BULK_PAGES_DEF = 8;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC      = 2'd0,
        FUNC_FREE       = 2'd1,
        FUNC_SET_ROOT   = 2'd2,
        FUNC_START_ROOT = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_SPACE = 2'd1,
        STATUS_BAD_FREE = 2'd2
    } status_t;

endpackage

/* rtl/core/pfla_req_if.sv */
// Request channel of the page allocator: valid/ready plus operation payload.
// Depends on pfla_pkg for field widths.
interface pfla_req_if;
    logic                        valid;
    logic                        ready;
    logic [pfla_pkg::FUNC_W-1:0] func;
    logic [pfla_pkg::PAGE_W-1:0] page_num;

    modport source (output valid, output func, output page_num, input ready);
    modport sink   (input valid, input func, input page_num, output ready);
endinterface

/* rtl/core/pfla_rsp_if.sv */
// Response channel of the page allocator: valid/ready plus result payload.
// Depends on pfla_pkg for field widths.
interface pfla_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [pfla_pkg::PAGE_W-1:0]   result_page;
    logic [pfla_pkg::PAGE_W-1:0]   root_page;
    logic [pfla_pkg::TOTAL_W-1:0]  pages_used;
    logic [pfla_pkg::STATUS_W-1:0] status;

    modport source (output valid, output result_page, output root_page,
                    output pages_used, output status, input ready);
    modport sink   (input valid, input result_page, input root_page,
                    input pages_used, input status, output ready);
endinterface

/* rtl/core/pfla_link_ram.sv */
// Next-link store of the free list: one write port, one read port, registered read.
// Depends on pfla_pkg for the link width.
module pfla_link_ram #(
    parameter int DEPTH = pfla_pkg::PAGE_COUNT_DEF,
    parameter int AW    = $clog2(pfla_pkg::PAGE_COUNT_DEF)
) (
    input  logic                        clk,
    input  logic                        wr_en,
    input  logic [AW-1:0]               wr_addr,
    input  logic [pfla_pkg::PAGE_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [AW-1:0]               rd_addr,
    output logic [pfla_pkg::PAGE_W-1:0] rd_data
);

    logic [pfla_pkg::PAGE_W-1:0] link_mem [DEPTH];
    logic [pfla_pkg::PAGE_W-1:0] rd_data_reg;

    // Entries hold no reset value: every link is written before it is read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= link_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/core/page_free_list_allocator_top.sv */
// Page allocator top level: free-list control, link store and result register.
// Depends on pfla_pkg, pfla_req_if, pfla_rsp_if, pfla_link_ram and the defines header.
//
// Each request transfer yields exactly one response transfer. A free, a set root
// and an alloc that fails for lack of space finish in the cycle of acceptance.
// An alloc or start root served from the free list passes through the pop state:
// the head's link is read from the single-port-read link store, whose data is
// registered, and is taken as the new head in the pop state. An alloc or start root
// with an empty list grows the file: the result is posted at once, after which
// the link store's one write port chains the other BULK_PAGES-1 new pages in
// the grow state. The link store has no reset and needs no clearing pass: every
// link is written before it is read. The result sits in an output register; in
// the idle state a new request is taken once that register is empty or is being
// drained in the same cycle.
`include "page_free_list_allocator_top_defines.svh"

module page_free_list_allocator_top #(
    parameter int PAGE_COUNT = pfla_pkg::PAGE_COUNT_DEF,
    parameter int BULK_PAGES = pfla_pkg::BULK_PAGES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    pfla_req_if.sink          req,
    pfla_rsp_if.source        rsp
);

    localparam int PW        = pfla_pkg::PAGE_W;
    localparam int AW        = $clog2(PAGE_COUNT);
    localparam int TW        = $clog2(PAGE_COUNT + 1);
    localparam int SW        = $clog2(PAGE_COUNT + BULK_PAGES + 1);
    localparam int CW        = TW + PW;
    localparam int GCW       = (BULK_PAGES > 2) ? $clog2(BULK_PAGES) : 1;
    localparam int GROW_LAST = (BULK_PAGES > 1) ? BULK_PAGES - 2 : 0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_GROW
    } state_t;

    state_t                        state_reg, state_next;
    logic [PW-1:0]                 free_head_reg, free_head_next;
    logic [PW-1:0]                 root_reg, root_next;
    logic [TW-1:0]                 page_total_reg, page_total_next;
    logic                          start_root_reg, start_root_next;
    logic [AW-1:0]                 grow_addr_reg, grow_addr_next;
    logic [GCW-1:0]                grow_cnt_reg, grow_cnt_next;
    logic                          out_valid_reg, out_valid_next;
    logic [PW-1:0]                 out_result_reg, out_result_next;
    logic [PW-1:0]                 out_root_reg, out_root_next;
    logic [pfla_pkg::TOTAL_W-1:0]  out_used_reg, out_used_next;
    pfla_pkg::status_t             out_status_reg, out_status_next;

    logic                          in_ready;
    logic                          req_fire;
    logic                          emit;
    logic [PW-1:0]                 result_val;
    pfla_pkg::status_t             status_val;
    logic                          space_ok;
    logic                          bad_free;
    logic [PW-1:0]                 grow_page;
    logic [TW-1:0]                 total_grown;
    logic                          grow_last;

    logic                          link_wr_en;
    logic [AW-1:0]                 link_wr_addr;
    logic [PW-1:0]                 link_wr_data;
    logic                          link_rd_en;
    logic [AW-1:0]                 link_rd_addr;
    logic [PW-1:0]                 link_rd_data;

    pfla_link_ram #(
        .DEPTH (PAGE_COUNT),
        .AW    (AW)
    ) u_link_ram (
        .clk     (clk),
        .wr_en   (link_wr_en),
        .wr_addr (link_wr_addr),
        .wr_data (link_wr_data),
        .rd_en   (link_rd_en),
        .rd_addr (link_rd_addr),
        .rd_data (link_rd_data)
    );

    // Accept only when idle and the result register is free by the next edge.
    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || rsp.ready);
    assign req.ready = in_ready;
    assign req_fire  = req.valid && in_ready;

    // Growth fits when the bulk ends at or below capacity.
    assign space_ok    = (SW'(page_total_reg) + SW'(BULK_PAGES)) <= SW'(PAGE_COUNT);
    assign grow_page   = PW'(SW'(page_total_reg) + SW'(BULK_PAGES - 1));
    assign total_grown = TW'(SW'(page_total_reg) + SW'(BULK_PAGES));
    assign bad_free    = (req.page_num == '0) ||
                         (CW'(req.page_num) >= CW'(page_total_reg));
    assign grow_last   = (grow_cnt_reg == GCW'(GROW_LAST));

    always_comb
    begin
        state_next      = state_reg;
        free_head_next  = free_head_reg;
        root_next       = root_reg;
        page_total_next = page_total_reg;
        start_root_next = start_root_reg;
        grow_addr_next  = grow_addr_reg;
        grow_cnt_next   = grow_cnt_reg;

        emit       = 1'b0;
        result_val = '0;
        status_val = pfla_pkg::STATUS_OK;

        link_wr_en   = 1'b0;
        link_wr_addr = '0;
        link_wr_data = '0;
        link_rd_en   = 1'b0;
        link_rd_addr = AW'(free_head_reg);

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    unique case (pfla_pkg::func_t'(req.func)) inside
                        pfla_pkg::FUNC_ALLOC, pfla_pkg::FUNC_START_ROOT:
                        begin
                            start_root_next = (req.func == pfla_pkg::FUNC_START_ROOT);
                            if (free_head_reg != '0)
                            begin
                                // Fetch the head's link; finish in the pop cycle.
                                link_rd_en = 1'b1;
                                state_next = ST_POP;
                            end
                            else if (!space_ok)
                            begin
                                emit       = 1'b1;
                                status_val = pfla_pkg::STATUS_NO_SPACE;
                            end
                            else
                            begin
                                emit            = 1'b1;
                                result_val      = grow_page;
                                page_total_next = total_grown;
                                if (req.func == pfla_pkg::FUNC_START_ROOT)
                                begin
                                    root_next = grow_page;
                                end
                                if (BULK_PAGES > 1)
                                begin
                                    free_head_next = PW'(page_total_reg);
                                    grow_addr_next = AW'(page_total_reg);
                                    grow_cnt_next  = '0;
                                    state_next     = ST_GROW;
                                end
                            end
                        end
                        pfla_pkg::FUNC_FREE:
                        begin
                            emit = 1'b1;
                            if (bad_free)
                            begin
                                status_val = pfla_pkg::STATUS_BAD_FREE;
                            end
                            else
                            begin
                                link_wr_en     = 1'b1;
                                link_wr_addr   = AW'(req.page_num);
                                link_wr_data   = free_head_reg;
                                free_head_next = req.page_num;
                            end
                        end
                        pfla_pkg::FUNC_SET_ROOT:
                        begin
                            emit      = 1'b1;
                            root_next = req.page_num;
                        end
                        default:
                        begin
                            emit = 1'b0;
                        end
                    endcase
                end
            end
            ST_POP:
            begin
                // Hand out the old head and advance to its link.
                emit           = 1'b1;
                result_val     = free_head_reg;
                free_head_next = link_rd_data;
                if (start_root_reg)
                begin
                    root_next = free_head_reg;
                end
                state_next = ST_IDLE;
            end
            ST_GROW:
            begin
                // Chain the new pages in ascending order; the last one ends the list.
                link_wr_en     = 1'b1;
                link_wr_addr   = grow_addr_reg;
                link_wr_data   = grow_last ? '0 : PW'(grow_addr_reg) + PW'(1);
                grow_addr_next = grow_addr_reg + AW'(1);
                grow_cnt_next  = grow_cnt_reg + GCW'(1);
                if (grow_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Result register: drop on a response transfer, load on emit.
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_result_next = out_result_reg;
        out_root_next   = out_root_reg;
        out_used_next   = out_used_reg;
        out_status_next = out_status_reg;
        if (emit)
        begin
            out_valid_next  = 1'b1;
            out_result_next = result_val;
            out_root_next   = root_next;
            out_used_next   = pfla_pkg::TOTAL_W'(page_total_next);
            out_status_next = status_val;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            free_head_reg  <= '0;
            root_reg       <= '0;
            page_total_reg <= TW'(1);
            start_root_reg <= 1'b0;
            grow_addr_reg  <= '0;
            grow_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_result_reg <= '0;
            out_root_reg   <= '0;
            out_used_reg   <= '0;
            out_status_reg <= pfla_pkg::STATUS_OK;
        end
        else
        begin
            state_reg      <= state_next;
            free_head_reg  <= free_head_next;
            root_reg       <= root_next;
            page_total_reg <= page_total_next;
            start_root_reg <= start_root_next;
            grow_addr_reg  <= grow_addr_next;
            grow_cnt_reg   <= grow_cnt_next;
            out_valid_reg  <= out_valid_next;
            out_result_reg <= out_result_next;
            out_root_reg   <= out_root_next;
            out_used_reg   <= out_used_next;
            out_status_reg <= out_status_next;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.result_page = out_result_reg;
    assign rsp.root_page   = out_root_reg;
    assign rsp.pages_used  = out_used_reg;
    assign rsp.status      = out_status_reg;

    `PFLA_ASSERT_NEXT(a_pop_posts_result, state_reg == ST_POP, rsp.valid, "pop finished without a result")
    `PFLA_ASSERT(a_no_space_zero, (rsp.valid && rsp.status == pfla_pkg::STATUS_NO_SPACE) |-> (rsp.result_page == '0), "out of space result carries a page")
    `PFLA_ASSERT(a_total_capped, page_total_reg <= TW'(PAGE_COUNT), "page total beyond capacity")
    `PFLA_ASSERT(a_stall_blocks_req, (rsp.valid && !rsp.ready) |-> !req.ready, "request taken over a stalled result")

endmodule

/* test/tb_page_free_list_allocator_top.sv */
// Testbench of the page free-list allocator: directed and random request streams with
// random idling on both channels, checked against a cycle-free predictor of the allocator.
// Depends on pfla_pkg, pfla_req_if, pfla_rsp_if and page_free_list_allocator_top.
module tb_page_free_list_allocator_top;
    import pfla_pkg::*;

    localparam int PG_COUNT    = PAGE_COUNT_DEF;
    localparam int BULK        = BULK_PAGES_DEF;
    // Growth posts its result at once and then chains BULK-1 links; allow for that and more.
    localparam int DRAIN_WAIT  = 4 * BULK + 8;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [PAGE_W-1:0]  page;
        logic [PAGE_W-1:0]  root;
        logic [TOTAL_W-1:0] used;
        status_t            status;
    } alloc_result_t;

    logic clk;
    logic rst_n;

    pfla_req_if req_ch ();
    pfla_rsp_if rsp_ch ();

    page_free_list_allocator_top #(
        .PAGE_COUNT(PG_COUNT),
        .BULK_PAGES(BULK)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req_ch),
        .rsp  (rsp_ch)
    );

    // Predictor state: the allocator's view of the file after every accepted transfer.
    logic [PAGE_W-1:0]  link_mem [PG_COUNT];
    logic [PAGE_W-1:0]  model_head;
    logic [PAGE_W-1:0]  model_root;
    logic [TOTAL_W-1:0] model_total;

    // Pages handed out and not yet given back; well-formed frees are drawn from here.
    logic [PAGE_W-1:0]  live_pages [$];

    alloc_result_t pending_results [$];
    int            error_count;
    int            cycle_count;
    bit            no_idle;   // when set, neither side idles
    int            rsp_hold;

    // ------------------------------------------------------------------
    // Clock, and the run limit: a hung block ends the run here.
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Idle lengths: mostly none or short, now and then long.
    // ------------------------------------------------------------------
    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // ------------------------------------------------------------------
    // Predictor. Pop the free-list head, or grow the file by a bulk when
    // the list is empty: return the last new page, chain the others in
    // ascending order, the last chained page ending the list. Return 0
    // when growth would pass capacity.
    // ------------------------------------------------------------------
    function automatic logic [PAGE_W-1:0] take_free_page();
        logic [PAGE_W-1:0] got;
        int                first;
        if (model_head != '0)
        begin
            got        = model_head;
            model_head = link_mem[got];
            return got;
        end
        if (int'(model_total) + BULK > PG_COUNT)
            return '0;
        first = int'(model_total);
        for (int i = 0; i + 1 < BULK; i++)
            link_mem[first + i] = (i + 2 < BULK) ? PAGE_W'(first + i + 1) : '0;
        if (BULK > 1)
            model_head = PAGE_W'(first);
        model_total = model_total + TOTAL_W'(BULK);
        return PAGE_W'(first + BULK - 1);
    endfunction

    function automatic alloc_result_t predict_alloc_step(func_t op, logic [PAGE_W-1:0] pn);
        alloc_result_t r;
        r.page   = '0;
        r.status = STATUS_OK;
        case (op)
            FUNC_ALLOC, FUNC_START_ROOT:
            begin
                r.page = take_free_page();
                if (r.page == '0)
                    r.status = STATUS_NO_SPACE;
                else
                begin
                    if (op == FUNC_START_ROOT)
                        model_root = r.page;
                    live_pages.push_back(r.page);
                end
            end
            FUNC_FREE:
            begin
                if (pn == '0 || {1'b0, pn} >= model_total)
                    r.status = STATUS_BAD_FREE;
                else
                begin
                    link_mem[pn] = model_head;
                    model_head   = pn;
                    // Drop one copy from the live set; a double free finds none.
                    for (int i = 0; i < live_pages.size(); i++)
                        if (live_pages[i] == pn)
                        begin
                            live_pages.delete(i);
                            break;
                        end
                end
            end
            default:
                model_root = pn;
        endcase
        r.root = model_root;
        r.used = model_total;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Send one request. Valid is lowered only when a gap precedes the
    // transfer, so a back-to-back request keeps it high without a second
    // assignment in the same step. Predict at the accepting edge.
    // ------------------------------------------------------------------
    task automatic send_request(input func_t op, input logic [PAGE_W-1:0] pn,
                                output alloc_result_t predicted);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid    <= 1'b1;
        req_ch.func     <= op;
        req_ch.page_num <= pn;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        predicted = predict_alloc_step(op, pn);
        pending_results.push_back(predicted);
    endtask

    // A free that must be refused: page 0, or a page at or beyond the file's end.
    function automatic logic [PAGE_W-1:0] refused_page();
        if ($urandom_range(0, 3) == 0 || int'(model_total) > PG_COUNT - 1)
            return '0;
        return PAGE_W'($urandom_range(int'(model_total), PG_COUNT - 1));
    endfunction

    function automatic logic [PAGE_W-1:0] pick_live_page();
        return live_pages[$urandom_range(0, live_pages.size() - 1)];
    endfunction

    // ------------------------------------------------------------------
    // Response side: stall at random, and check every transfer against
    // the oldest prediction.
    // ------------------------------------------------------------------
    initial
    begin
        rsp_ch.ready <= 1'b0;
        rsp_hold = 0;
        forever
        begin
            @(posedge clk);
            if (no_idle)
            begin
                rsp_ch.ready <= 1'b1;
                rsp_hold = 0;
            end
            else if (rsp_hold > 0)
                rsp_hold--;
            else if (rsp_ch.ready)
            begin
                rsp_hold = next_gap();
                if (rsp_hold > 0)
                begin
                    rsp_ch.ready <= 1'b0;
                    rsp_hold--;
                end
                else
                    rsp_hold = $urandom_range(0, 6);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
                rsp_hold = $urandom_range(0, 6);
            end
        end
    end

    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("response transfer with no request outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.result_page !== want.page)
                begin
                    $error("result_page: expected %0d, got %0d", want.page, rsp_ch.result_page);
                    error_count++;
                end
                if (rsp_ch.root_page !== want.root)
                begin
                    $error("root_page: expected %0d, got %0d", want.root, rsp_ch.root_page);
                    error_count++;
                end
                if (rsp_ch.pages_used !== want.used)
                begin
                    $error("pages_used: expected %0d, got %0d", want.used, rsp_ch.pages_used);
                    error_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp_ch.status);
                    error_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Every operation once or more, frees on both sides of the file's end (the one
    // past it refused), the first growth, the last page of a bulk, and root extremes.
    task automatic test_directed_ops();
        alloc_result_t r;
        send_request(FUNC_FREE,       10'd1,   r);   // beyond a header-only file
        send_request(FUNC_FREE,       10'd0,   r);   // header page
        send_request(FUNC_ALLOC,      10'h3FF, r);   // first growth, page_num ignored
        send_request(FUNC_ALLOC,      10'd0,   r);   // pop
        send_request(FUNC_START_ROOT, 10'd0,   r);
        send_request(FUNC_FREE,       PAGE_W'(BULK), r);     // last page in the file
        send_request(FUNC_FREE,       PAGE_W'(BULK + 1), r); // first page past the end
        send_request(FUNC_FREE,       10'h3FF, r);
        send_request(FUNC_ALLOC,      10'h155, r);
        send_request(FUNC_SET_ROOT,   10'h3FF, r);
        send_request(FUNC_SET_ROOT,   10'd0,   r);   // clear the tree
        send_request(FUNC_SET_ROOT,   10'h155, r);
        send_request(FUNC_SET_ROOT,   10'h2AA, r);
        send_request(FUNC_START_ROOT, 10'h3FF, r);
        send_request(FUNC_FREE,       10'd1,   r);
        send_request(FUNC_FREE,       10'd2,   r);
        send_request(FUNC_ALLOC,      10'h2AA, r);
        send_request(FUNC_ALLOC,      10'd0,   r);
        send_request(FUNC_ALLOC,      10'd0,   r);
    endtask

    // Mostly allocations and well-formed frees, with refused frees and root
    // loads mixed in; the file grows steadily. Two stretches run with no idling.
    task automatic test_random_mix(input int count);
        alloc_result_t r;
        int            pick;
        for (int n = 0; n < count; n++)
        begin
            no_idle = (n >= 150 && n < 250) || (n >= 380 && n < 430);
            pick = $urandom_range(0, 99);
            if (pick < 35 || (pick >= 45 && pick < 75 && live_pages.size() == 0))
                send_request(FUNC_ALLOC, PAGE_W'($urandom), r);
            else if (pick < 45)
                send_request(FUNC_START_ROOT, PAGE_W'($urandom), r);
            else if (pick < 75)
                send_request(FUNC_FREE, pick_live_page(), r);
            else if (pick < 85)
                send_request(FUNC_FREE, refused_page(), r);
            else
                send_request(FUNC_SET_ROOT, PAGE_W'($urandom), r);
        end
        no_idle = 1'b0;
    endtask

    // Give pages back and reuse them, so freed pages circulate and the
    // list runs dry now and then.
    task automatic test_reuse_at_capacity(input int count);
        alloc_result_t r;
        int            pick;
        for (int n = 0; n < count; n++)
        begin
            no_idle = (n >= 100 && n < 150);
            pick = $urandom_range(0, 99);
            if (pick < 45 && live_pages.size() != 0)
                send_request(FUNC_FREE, pick_live_page(), r);
            else if (pick < 55)
                send_request(FUNC_FREE, refused_page(), r);
            else if (pick < 85)
                send_request(FUNC_ALLOC, PAGE_W'($urandom), r);
            else if (pick < 95)
                send_request(FUNC_START_ROOT, PAGE_W'($urandom), r);
            else
                send_request(FUNC_SET_ROOT, PAGE_W'($urandom), r);
        end
        no_idle = 1'b0;
    endtask

    // A double free is not caught: the page links to itself and is handed
    // out again and again.
    task automatic test_double_free();
        alloc_result_t r;
        logic [PAGE_W-1:0] victim;
        send_request(FUNC_ALLOC, 10'd0, r);
        victim = (r.status == STATUS_OK) ? r.page : PAGE_W'(model_total - 1'b1);
        send_request(FUNC_FREE,  victim, r);
        send_request(FUNC_FREE,  victim, r);
        send_request(FUNC_ALLOC, 10'd0,  r);
        send_request(FUNC_ALLOC, 10'd0,  r);
    endtask

    // ------------------------------------------------------------------
    // Main sequence: reset once, run the tests in turn, drain, report.
    // ------------------------------------------------------------------
    initial
    begin
        error_count = 0;
        no_idle     = 1'b0;
        model_head  = '0;
        model_root  = '0;
        model_total = TOTAL_W'(1);
        foreach (link_mem[i])
            link_mem[i] = '0;

        rst_n           <= 1'b0;
        req_ch.valid    <= 1'b0;
        req_ch.func     <= FUNC_ALLOC;
        req_ch.page_num <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_ops();
        test_random_mix(470);
        test_reuse_at_capacity(250);
        test_double_free();

        // Hold valid low once the last transfer is in, then let the results drain.
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
